// ===== rtl/core/prm_pkg.sv =====
// Package for the pulse rate meter: sizes, constants, sequencer states and register indexes.
// Used by prm_divider, pulse_rate_meter_with_decay and the testbench; depends on nothing.
package prm_pkg;

    localparam int WINDOW = 3;
    localparam int RIDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W = $clog2(WINDOW + 1);
    localparam int PERIOD_W = 16;
    localparam int SUM_W = PERIOD_W + COUNT_W;
    localparam int DEN_W = SUM_W + 3;
    localparam int NUM_W = 27 + COUNT_W;
    localparam int TIME_W = 32;
    localparam int LEVEL_W = 16;
    localparam int PCT_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0] RING_RESET_VALUE = 16'd10000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd27306;
    localparam logic [26:0] RATE_SCALE = 27'd81920000;
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [8:0] PCT_ODD = 9'd166;
    localparam logic [8:0] PCT_MAX = 9'd100;

    localparam logic [7:0] QUALIFY_RESET = 8'd5;
    localparam logic [15:0] MIN_PERIOD_RESET = 16'd100;
    localparam logic [15:0] DECAY_DELAY_RESET = 16'd1500;
    localparam logic [15:0] DECAY_STEP_RESET = 16'd250;
    localparam logic [7:0] DECAY_FACTOR_RESET = 8'd179;
    localparam logic [15:0] REPORT_RESET = 16'd250;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DECAY,
        ST_REPORT,
        ST_DONE
    } prm_state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUALIFY = 3'd0,
        REG_MIN_PERIOD = 3'd1,
        REG_DECAY_DELAY = 3'd2,
        REG_DECAY_STEP = 3'd3,
        REG_DECAY_FACTOR = 3'd4,
        REG_REPORT = 3'd5
    } prm_cfg_reg_t;

    typedef struct packed {
        logic start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } prm_div_req_t;

endpackage

// ===== rtl/core/prm_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on prm_pkg for operand widths and the request struct.
module prm_divider
    import prm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  prm_div_req_t req,
    output logic done,
    output logic [NUM_W-1:0] quot
);

    localparam int ITER_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [ITER_W-1:0] iter_reg;
    logic busy_reg;
    logic done_reg;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic fits;

    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff = trial - {1'b0, den_reg};
    assign fits = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/core/pulse_rate_meter_with_decay.sv =====
// Top level of the pulse rate meter with idle decay: one switch sample per transfer in,
// one result transfer out. Depends on prm_pkg and prm_divider.
// A tick without a pulse passes the edge, decay and report states; a pulse first sums the
// window ring and, when a ring entry is above the minimum period, runs the one-bit-per-cycle
// divider. Input is not ready while an item is in progress, so a new sample is taken only
// after the last result has gone to the output register, later while the output is stalled.
// Reset is asynchronous and active low; it loads the register defaults and a full ring.
module pulse_rate_meter_with_decay
    import prm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [0] switch_level, [7:1] zero
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] percent, [7] report_now, [8] pulse_taken
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    prm_state_t state_reg;
    prm_state_t state_next;

    logic [7:0] qualify_reg;
    logic [15:0] min_period_reg;
    logic [15:0] decay_delay_reg;
    logic [15:0] decay_step_reg;
    logic [7:0] decay_factor_reg;
    logic [15:0] report_ms_reg;

    logic [TIME_W-1:0] now_reg;
    logic prev_level_reg;
    logic armed_reg;
    logic cur_reg;
    logic [TIME_W-1:0] edge_time_reg;
    logic [TIME_W-1:0] last_pulse_reg;
    logic [TIME_W-1:0] decay_start_reg;
    logic [TIME_W-1:0] decay_time_reg;
    logic [TIME_W-1:0] report_time_reg;
    logic [PERIOD_W-1:0] ring_reg [WINDOW];
    logic [RIDX_W-1:0] ring_idx_reg;
    logic [RIDX_W-1:0] sum_idx_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [PCT_W-1:0] percent_reg;
    logic report_reg;
    logic pulse_reg;

    logic m_valid_reg;
    logic [15:0] m_data_reg;

    logic rising;
    logic pulse_hit;
    logic [TIME_W-1:0] period_full;
    logic [PERIOD_W-1:0] period_sat;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_step;
    logic [TIME_W-1:0] since_report;
    logic decay_hit;
    logic report_hit;
    logic [LEVEL_W+7:0] decay_prod;
    logic [LEVEL_W+6:0] pct_prod;
    logic [8:0] pct_raw;
    logic [PCT_W-1:0] pct_final;
    logic [PERIOD_W-1:0] ring_rd;
    logic out_free;

    prm_div_req_t div_req;
    logic div_done;
    logic [NUM_W-1:0] div_quot;

    prm_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .done (div_done),
        .quot (div_quot)
    );

    assign rising = cur_reg && !prev_level_reg;
    assign pulse_hit = cur_reg && armed_reg && !rising
                       && ((now_reg - edge_time_reg) > TIME_W'(qualify_reg));
    assign period_full = now_reg - last_pulse_reg;
    assign period_sat = (period_full > TIME_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                            : period_full[PERIOD_W-1:0];
    assign since_start = now_reg - decay_start_reg;
    assign since_step = now_reg - decay_time_reg;
    assign since_report = now_reg - report_time_reg;
    assign decay_hit = (since_start > TIME_W'(decay_delay_reg))
                       && (since_step > TIME_W'(decay_step_reg));
    assign report_hit = since_report > TIME_W'(report_ms_reg);
    assign decay_prod = (LEVEL_W+8)'(level_reg) * (LEVEL_W+8)'(decay_factor_reg);
    assign pct_prod = (LEVEL_W+7)'(level_reg) * (LEVEL_W+7)'(PCT_SCALE);
    assign pct_raw = pct_prod[LEVEL_W+6:14];
    assign ring_rd = ring_reg[sum_idx_reg];
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        if (pct_raw == PCT_ODD)
        begin
            pct_final = '0;
        end
        else if (pct_raw > PCT_MAX)
        begin
            pct_final = PCT_W'(PCT_MAX);
        end
        else
        begin
            pct_final = pct_raw[PCT_W-1:0];
        end
    end

    always_comb
    begin
        div_req.start = (state_reg == ST_DIV_START) && (count_reg != '0);
        div_req.num = NUM_W'(RATE_SCALE) * NUM_W'(count_reg);
        div_req.den = DEN_W'({sum_reg, 2'b00}) + DEN_W'({sum_reg, 1'b0});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                state_next = pulse_hit ? ST_SUM : ST_DECAY;
            end
            ST_SUM:
            begin
                if (sum_idx_reg == RIDX_W'(WINDOW - 1))
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                state_next = (count_reg == '0) ? ST_DECAY : ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_DECAY;
                end
            end
            ST_DECAY:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qualify_reg <= QUALIFY_RESET;
            min_period_reg <= MIN_PERIOD_RESET;
            decay_delay_reg <= DECAY_DELAY_RESET;
            decay_step_reg <= DECAY_STEP_RESET;
            decay_factor_reg <= DECAY_FACTOR_RESET;
            report_ms_reg <= REPORT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (prm_cfg_reg_t'(cfg_index))
                REG_QUALIFY: qualify_reg <= cfg_data[7:0];
                REG_MIN_PERIOD: min_period_reg <= cfg_data;
                REG_DECAY_DELAY: decay_delay_reg <= cfg_data;
                REG_DECAY_STEP: decay_step_reg <= cfg_data;
                REG_DECAY_FACTOR: decay_factor_reg <= cfg_data[7:0];
                REG_REPORT: report_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
            prev_level_reg <= 1'b0;
            armed_reg <= 1'b0;
            cur_reg <= 1'b0;
            edge_time_reg <= '0;
            last_pulse_reg <= '0;
            decay_start_reg <= '0;
            decay_time_reg <= '0;
            report_time_reg <= '0;
            for (int k = 0; k < WINDOW; k++)
            begin
                ring_reg[k] <= RING_RESET_VALUE;
            end
            ring_idx_reg <= '0;
            sum_idx_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            level_reg <= '0;
            percent_reg <= '0;
            report_reg <= 1'b0;
            pulse_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
        end
        else
        begin
            if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cur_reg <= s_axis_tdata[0];
                        report_reg <= 1'b0;
                        pulse_reg <= 1'b0;
                    end
                end
                ST_EDGE:
                begin
                    prev_level_reg <= cur_reg;
                    sum_idx_reg <= '0;
                    sum_reg <= '0;
                    count_reg <= '0;
                    if (rising)
                    begin
                        edge_time_reg <= now_reg;
                        armed_reg <= 1'b1;
                    end
                    if (pulse_hit)
                    begin
                        last_pulse_reg <= now_reg;
                        decay_start_reg <= now_reg;
                        decay_time_reg <= now_reg;
                        ring_reg[ring_idx_reg] <= period_sat;
                        ring_idx_reg <= (ring_idx_reg == RIDX_W'(WINDOW - 1))
                                        ? '0 : ring_idx_reg + 1'b1;
                        armed_reg <= 1'b0;
                        pulse_reg <= 1'b1;
                    end
                end
                ST_SUM:
                begin
                    if (ring_rd > min_period_reg)
                    begin
                        sum_reg <= sum_reg + SUM_W'(ring_rd);
                        count_reg <= count_reg + 1'b1;
                    end
                    sum_idx_reg <= sum_idx_reg + 1'b1;
                end
                ST_DIV_START:
                begin
                    if (count_reg == '0)
                    begin
                        level_reg <= '0;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        level_reg <= (div_quot > NUM_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                                   : div_quot[LEVEL_W-1:0];
                    end
                end
                ST_DECAY:
                begin
                    if (decay_hit)
                    begin
                        decay_time_reg <= now_reg;
                        level_reg <= decay_prod[LEVEL_W+7:8];
                    end
                end
                ST_REPORT:
                begin
                    if (report_hit)
                    begin
                        report_time_reg <= now_reg;
                        percent_reg <= pct_final;
                        report_reg <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        now_reg <= now_reg + 1'b1;
                        m_valid_reg <= 1'b1;
                        m_data_reg <= {7'd0, pulse_reg, report_reg, percent_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

// ===== test/tb_pulse_rate_meter_with_decay.sv =====
// Self-checking testbench for pulse_rate_meter_with_decay: switch samples stream in,
// every result transfer is compared with a local model of the tachometer and its decay.
// Depends on prm_pkg and the RTL of the block; needs no files or arguments.
module tb_pulse_rate_meter_with_decay;
    import prm_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int SQUEEZE_CYCLES = 400;

    typedef struct packed {
        logic [PCT_W-1:0] percent;
        logic report;
        logic pulse;
    } meter_out_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        prm_cfg_reg_t idx;
        logic [15:0] value;
        logic sw;
        logic typed;
        meter_out_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic quiet = 1'b0;
    logic squeeze_go = 1'b0;
    logic squeeze_done = 1'b0;
    int hold_left = 0;

    logic switch_q [$];
    meter_out_t expected_q [$];
    script_row_t typed_q [$];

    int error_count = 0;
    int samples_sent = 0;
    int reports_seen = 0;
    int pulses_seen = 0;
    int phase_count = 0;
    int cycle_count = 0;

    // Shadow of the register file.
    logic [7:0] cfg_qualify = QUALIFY_RESET;
    logic [15:0] cfg_min_period = MIN_PERIOD_RESET;
    logic [15:0] cfg_decay_delay = DECAY_DELAY_RESET;
    logic [15:0] cfg_decay_step = DECAY_STEP_RESET;
    logic [7:0] cfg_factor = DECAY_FACTOR_RESET;
    logic [15:0] cfg_report = REPORT_RESET;

    // Tachometer state.
    logic [TIME_W-1:0] now_t = '0;
    logic [TIME_W-1:0] edge_at = '0;
    logic [TIME_W-1:0] pulse_at = '0;
    logic [TIME_W-1:0] decay_from = '0;
    logic [TIME_W-1:0] decay_at = '0;
    logic [TIME_W-1:0] report_at = '0;
    logic last_sw = 1'b0;
    logic armed = 1'b0;
    logic [PERIOD_W-1:0] period_hist [WINDOW] = '{default: RING_RESET_VALUE};
    int hist_pos = 0;
    logic [LEVEL_W-1:0] level = '0;
    logic [PCT_W-1:0] shown_pct = '0;

    script_row_t script [26] = '{
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b1, '{7'd0,   1'b0, 1'b0}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b0, 1'b0}},
        '{ROW_WRITE, REG_QUALIFY,      16'd0,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_MIN_PERIOD,   16'd0,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_REPORT,       16'd0,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DECAY_DELAY,  16'd0,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DECAY_STEP,   16'd0,     1'b0, 1'b0, '0},
        '{ROW_WRITE, REG_DECAY_FACTOR, 16'd255,   1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b1, 1'b1}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b1, '{7'd0,   1'b1, 1'b0}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b1, '{7'd100, 1'b1, 1'b0}},
        '{ROW_WRITE, REG_DECAY_FACTOR, 16'd0,     1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b1, '{7'd0,   1'b1, 1'b0}},
        '{ROW_WRITE, REG_MIN_PERIOD,   16'd65535, 1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b1, 1'b0}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b1, 1'b1}},
        '{ROW_WRITE, REG_QUALIFY,      16'd255,   1'b0, 1'b0, '0},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b0, 1'b1, '{7'd0,   1'b1, 1'b0}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b1, 1'b0}},
        '{ROW_TICK,  REG_QUALIFY,      16'd0,     1'b1, 1'b1, '{7'd0,   1'b1, 1'b0}}
    };

    pulse_rate_meter_with_decay DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [LEVEL_W-1:0] ring_rate();
        logic [63:0] total;
        logic [63:0] valid_n;
        logic [63:0] q;
        total = '0;
        valid_n = '0;
        for (int k = 0; k < WINDOW; k++)
        begin
            if (period_hist[k] > cfg_min_period)
            begin
                total += period_hist[k];
                valid_n++;
            end
        end
        if (valid_n == 0)
            return '0;
        q = (64'(RATE_SCALE) * valid_n) / (64'd6 * total);
        if (q > LEVEL_MAX)
            q = LEVEL_MAX;
        return q[LEVEL_W-1:0];
    endfunction

    function automatic meter_out_t meter_tick(input logic sw);
        meter_out_t res;
        logic [TIME_W-1:0] gap;
        logic [31:0] scaled;
        res = '0;
        if (sw && !last_sw)
        begin
            edge_at = now_t;
            armed = 1'b1;
        end
        last_sw = sw;
        if (sw && armed && (now_t - edge_at) > cfg_qualify)
        begin
            gap = now_t - pulse_at;
            period_hist[hist_pos] = (gap > PERIOD_MAX) ? PERIOD_MAX : gap[PERIOD_W-1:0];
            hist_pos = (hist_pos + 1 >= WINDOW) ? 0 : hist_pos + 1;
            pulse_at = now_t;
            decay_from = now_t;
            decay_at = now_t;
            level = ring_rate();
            armed = 1'b0;
            res.pulse = 1'b1;
        end
        if ((now_t - decay_from) > cfg_decay_delay && (now_t - decay_at) > cfg_decay_step)
        begin
            decay_at = now_t;
            scaled = level * cfg_factor;
            level = scaled[23:8];
        end
        if ((now_t - report_at) > cfg_report)
        begin
            report_at = now_t;
            scaled = (level * 32'd100) >> 14;
            if (scaled == PCT_ODD)
                scaled = 0;
            if (scaled > PCT_MAX)
                scaled = PCT_MAX;
            shown_pct = scaled[PCT_W-1:0];
            res.report = 1'b1;
        end
        now_t = now_t + 1;
        res.percent = shown_pct;
        return res;
    endfunction

    function automatic void compare_result(input string what, input meter_out_t want,
                                           input meter_out_t got);
        if (want.percent !== got.percent)
        begin
            error_count++;
            $display("%0t: %s percent expected %0d, got %0d", $time, what, want.percent,
                     got.percent);
        end
        if (want.report !== got.report)
        begin
            error_count++;
            $display("%0t: %s report_now expected %0b, got %0b", $time, what, want.report,
                     got.report);
        end
        if (want.pulse !== got.pulse)
        begin
            error_count++;
            $display("%0t: %s pulse_taken expected %0b, got %0b", $time, what, want.pulse,
                     got.pulse);
        end
    endfunction

    always @(posedge clk)
    begin : feed
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_q.push_back(meter_tick(s_axis_tdata[0]));
            samples_sent++;
        end
        if (rst_n && (!s_axis_tvalid || s_axis_tready))
        begin
            if (switch_q.size() != 0 && (quiet || $urandom_range(99) >= 25))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'd0, switch_q.pop_front()};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : sink
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (squeeze_go && !squeeze_done)
        begin
            squeeze_done = 1'b1;
            hold_left = SQUEEZE_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && (quiet || $urandom_range(99) >= 25);
    end

    always @(posedge clk)
    begin : check_results
        meter_out_t got;
        script_row_t row;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.percent = m_axis_tdata[6:0];
            got.report = m_axis_tdata[7];
            got.pulse = m_axis_tdata[8];
            reports_seen += got.report;
            pulses_seen += got.pulse;
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result %h arrived with nothing expected", $time, m_axis_tdata);
            end
            else
                compare_result("model", expected_q.pop_front(), got);
            if (typed_q.size() != 0)
            begin
                row = typed_q.pop_front();
                if (row.typed)
                    compare_result("table", row.want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic settle();
        do
            @(negedge clk);
        while (switch_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input prm_cfg_reg_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_QUALIFY: cfg_qualify = val[7:0];
            REG_MIN_PERIOD: cfg_min_period = val;
            REG_DECAY_DELAY: cfg_decay_delay = val;
            REG_DECAY_STEP: cfg_decay_step = val;
            REG_DECAY_FACTOR: cfg_factor = val[7:0];
            REG_REPORT: cfg_report = val;
            default: ;
        endcase
    endtask

    task automatic program_meter(input int qual, input int minp, input int dly,
                                 input int stp, input int fac, input int rep);
        settle();
        write_reg(REG_QUALIFY, 16'(qual));
        write_reg(REG_MIN_PERIOD, 16'(minp));
        write_reg(REG_DECAY_DELAY, 16'(dly));
        write_reg(REG_DECAY_STEP, 16'(stp));
        write_reg(REG_DECAY_FACTOR, 16'(fac));
        write_reg(REG_REPORT, 16'(rep));
        phase_count++;
    endtask

    // Switch activity as high and low runs; short high runs fail to qualify, and
    // the noise share scatters single random samples between the runs.
    task automatic queue_bursts(input int n, input int hi_min, input int hi_max,
                                input int lo_min, input int lo_max, input int noise_pct);
        int made;
        int len;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(99) < noise_pct)
            begin
                switch_q.push_back(1'($urandom_range(1)));
                made++;
            end
            else
            begin
                len = $urandom_range(hi_max, hi_min);
                repeat (len) switch_q.push_back(1'b1);
                made += len;
                len = $urandom_range(lo_max, lo_min);
                repeat (len) switch_q.push_back(1'b0);
                made += len;
            end
        end
    endtask

    initial
    begin : run
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(script[i].idx, script[i].value);
            end
            else
            begin
                switch_q.push_back(script[i].sw);
                typed_q.push_back(script[i]);
            end
        end

        program_meter($urandom_range(3), $urandom_range(20), $urandom_range(30),
                      $urandom_range(8), $urandom_range(255), $urandom_range(10));
        queue_bursts(150, 1, 8, 1, 12, 10);

        program_meter($urandom_range(10), $urandom_range(120, 20), $urandom_range(300, 20),
                      $urandom_range(60, 1), $urandom_range(255, 128), $urandom_range(50, 1));
        queue_bursts(220, 1, 25, 20, 120, 5);

        program_meter($urandom_range(3), $urandom_range(20), $urandom_range(30),
                      $urandom_range(8), $urandom_range(255), $urandom_range(10));
        squeeze_go <= 1'b1;
        queue_bursts(120, 1, 8, 1, 12, 10);

        program_meter(QUALIFY_RESET, $urandom_range(10), $urandom_range(20),
                      $urandom_range(4), $urandom_range(255), $urandom_range(3));
        queue_bursts(80, 1, 3, 1, 3, 60);

        // Both sides run without idle cycles for the last phase.
        program_meter(255, 0, 65535, 65535, 255, 65535);
        quiet <= 1'b1;
        queue_bursts(60, 1, 10, 1, 10, 20);
        settle();

        $display("Checked %0d switch samples with %0d reports and %0d measured pulses.",
                 samples_sent, reports_seen, pulses_seen);
        $display("Register settings changed over %0d phases, with extremes and a long stall.",
                 phase_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
